>>> rtl/reverb_comb_allpass_delay_unit_defines.svh
// assertion macros for the reverb comb / allpass delay unit
// used by the port-level checker, expects clk_i and rst_ni in scope
`ifndef REVERB_COMB_ALLPASS_DELAY_UNIT_DEFINES_SVH
`define REVERB_COMB_ALLPASS_DELAY_UNIT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define RCAD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rcad assertion failed");

// next-cycle implication, disabled while in reset
`define RCAD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rcad assertion failed");

`endif

>>> rtl/rcad_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and q15 arithmetic for the reverb delay unit
// no dependencies
package rcad_pkg;

  // delay line geometry
  localparam int DELAY_DEPTH = 4096;
  localparam int PTR_W       = $clog2(DELAY_DEPTH);
  localparam int SMP_W       = 16;
  localparam int DLEN_W      = 13;
  localparam int CNT_W       = (PTR_W + 1 > DLEN_W) ? PTR_W + 1 : DLEN_W;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DRY_GAIN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WET_GAIN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_LENGTH  = 3'd4;

  // filter modes
  localparam logic MODE_COMB    = 1'b0;
  localparam logic MODE_ALLPASS = 1'b1;

  // reset values of the registers
  localparam logic signed [SMP_W-1:0] DRY_GAIN_RST      = 16'sd19661;
  localparam logic signed [SMP_W-1:0] WET_GAIN_RST      = 16'sd22938;
  localparam logic signed [SMP_W-1:0] FEEDBACK_GAIN_RST = 16'sd26214;
  localparam logic [DLEN_W-1:0]       DELAY_LENGTH_RST  = 13'd3528;

  localparam logic signed [SMP_W-1:0] SMP_MAX = 16'sh7fff;
  localparam logic signed [SMP_W-1:0] SMP_MIN = 16'sh8000;

  // position of one transaction in the delay line
  typedef struct packed {
    logic [PTR_W-1:0] addr;
    logic             filled;
  } line_pos_t;

  // clamp a 17-bit value to 16 bits
  function automatic logic signed [SMP_W-1:0] sat17(input logic signed [SMP_W:0] v);
    logic signed [SMP_W-1:0] r;
    if (v[SMP_W] == v[SMP_W-1]) begin
      r = v[SMP_W-1:0];
    end else if (v[SMP_W]) begin
      r = SMP_MIN;
    end else begin
      r = SMP_MAX;
    end
    return r;
  endfunction

  // q15 product, floor shift, saturated
  function automatic logic signed [SMP_W-1:0] q15_mul(input logic signed [SMP_W-1:0] a,
                                                      input logic signed [SMP_W-1:0] b);
    logic signed [2*SMP_W-1:0] prod;
    prod = a * b;
    return sat17(prod[2*SMP_W-1:SMP_W-1]);
  endfunction

  // saturated add of two 16-bit values
  function automatic logic signed [SMP_W-1:0] sat_add(input logic signed [SMP_W-1:0] a,
                                                      input logic signed [SMP_W-1:0] b);
    logic signed [SMP_W:0] s;
    s = {a[SMP_W-1], a} + {b[SMP_W-1], b};
    return sat17(s);
  endfunction

  // negation with the most negative value mapped to the maximum
  function automatic logic signed [SMP_W-1:0] neg_sat(input logic signed [SMP_W-1:0] a);
    logic signed [SMP_W-1:0] r;
    if (a == SMP_MIN) begin
      r = SMP_MAX;
    end else begin
      r = -a;
    end
    return r;
  endfunction

endpackage

>>> rtl/rcad_ram.sv
`timescale 1ns / 1ps
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module rcad_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/rcad_line_ctrl.sv
`timescale 1ns / 1ps
// circular pointer and first-pass flag of the delay line
// depends on rcad_pkg
module rcad_line_ctrl
  import rcad_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [DLEN_W-1:0] delay_length_i,
  input  logic              advance_i,
  output line_pos_t         pos_o
);

  logic [PTR_W-1:0] ptr_q, ptr_d;
  logic             filled_q, filled_d;
  logic [CNT_W-1:0] len;
  logic [CNT_W-1:0] dl_ext;
  logic [CNT_W-1:0] nxt;
  logic             wrap;

  // effective length, clamped to 1..depth
  assign dl_ext = CNT_W'(delay_length_i);
  always_comb begin
    if (dl_ext == '0) begin
      len = CNT_W'(1);
    end else if (dl_ext > CNT_W'(DELAY_DEPTH)) begin
      len = CNT_W'(DELAY_DEPTH);
    end else begin
      len = dl_ext;
    end
  end

  // pointer beyond a shortened line restarts at zero
  assign wrap         = CNT_W'(ptr_q) >= len;
  assign pos_o.addr   = wrap ? '0 : ptr_q;
  assign pos_o.filled = filled_q | wrap;

  // advance and wrap
  assign nxt = CNT_W'(pos_o.addr) + CNT_W'(1);
  always_comb begin
    if (nxt >= len) begin
      ptr_d    = '0;
      filled_d = 1'b1;
    end else begin
      ptr_d    = nxt[PTR_W-1:0];
      filled_d = pos_o.filled;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q    <= '0;
      filled_q <= 1'b0;
    end else if (advance_i) begin
      ptr_q    <= ptr_d;
      filled_q <= filled_d;
    end
  end

endmodule

>>> rtl/rcad_pipe.sv
`timescale 1ns / 1ps
// sample pipeline: gains, delay ram read-modify-write, output register
// depends on rcad_pkg
module rcad_pipe
  import rcad_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // input transaction
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [SMP_W-1:0] sample_in_i,
  output logic                    accept_o,
  input  line_pos_t               pos_i,
  // configuration
  input  logic                    filter_mode_i,
  input  logic signed [SMP_W-1:0] dry_gain_i,
  input  logic signed [SMP_W-1:0] wet_gain_i,
  input  logic signed [SMP_W-1:0] feedback_gain_i,
  // delay ram
  output logic                    ram_re_o,
  output logic [PTR_W-1:0]        ram_raddr_o,
  input  logic [SMP_W-1:0]        ram_rdata_i,
  output logic                    ram_we_o,
  output logic [PTR_W-1:0]        ram_waddr_o,
  output logic [SMP_W-1:0]        ram_wdata_o,
  // output transaction
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [SMP_W-1:0] sample_out_o
);

  logic                    s1_v_q, s2_v_q, out_v_q;
  logic [PTR_W-1:0]        s1_addr_q, s2_addr_q;
  logic                    s1_filled_q, s2_filled_q;
  logic signed [SMP_W-1:0] s1_base_q, s2_base_q;
  logic signed [SMP_W-1:0] s1_dir_q, s2_dir_q;
  logic signed [SMP_W-1:0] s2_d_q, s2_fbd_q;
  logic signed [SMP_W-1:0] out_q;

  logic                    en_out, en2, en1, hazard;
  logic signed [SMP_W-1:0] base_d, dir_d, fbd_d, store_d, y_d;

  // stage enables, bubbles collapse
  assign en_out = !out_v_q || !out_stall_i;
  assign en2    = !s2_v_q || en_out;
  assign en1    = !s1_v_q || en2;

  // entry still waiting for its write-back in stage 1 or 2
  assign hazard = (s1_v_q && (s1_addr_q == pos_i.addr)) ||
                  (s2_v_q && (s2_addr_q == pos_i.addr));

  assign in_stall_o = !en1 || hazard;
  assign accept_o   = in_valid_i && !in_stall_o;

  // read of the delay entry issued with the accept
  assign ram_re_o    = accept_o;
  assign ram_raddr_o = pos_i.addr;

  // direct and stored terms of the input sample
  always_comb begin
    if (filter_mode_i == MODE_ALLPASS) begin
      base_d = sample_in_i;
      dir_d  = q15_mul(sample_in_i, neg_sat(feedback_gain_i));
    end else begin
      base_d = q15_mul(sample_in_i, wet_gain_i);
      dir_d  = q15_mul(sample_in_i, dry_gain_i);
    end
  end

  // feedback product of the delayed sample
  assign fbd_d = q15_mul($signed(ram_rdata_i), feedback_gain_i);

  // sums, first pass leaves out the delayed terms
  always_comb begin
    if (s2_filled_q) begin
      store_d = sat_add(s2_base_q, s2_fbd_q);
      y_d     = sat_add(s2_dir_q, s2_d_q);
    end else begin
      store_d = s2_base_q;
      y_d     = s2_dir_q;
    end
  end

  // write-back as stage 2 moves to the output register
  assign ram_we_o    = s2_v_q && en_out;
  assign ram_waddr_o = s2_addr_q;
  assign ram_wdata_o = store_d;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en1) begin
        s1_v_q <= accept_o;
      end
      if (en2) begin
        s2_v_q <= s1_v_q;
      end
      if (en_out) begin
        out_v_q <= s2_v_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept_o) begin
      s1_addr_q   <= pos_i.addr;
      s1_filled_q <= pos_i.filled;
      s1_base_q   <= base_d;
      s1_dir_q    <= dir_d;
    end
    if (en2 && s1_v_q) begin
      s2_addr_q   <= s1_addr_q;
      s2_filled_q <= s1_filled_q;
      s2_base_q   <= s1_base_q;
      s2_dir_q    <= s1_dir_q;
      s2_d_q      <= $signed(ram_rdata_i);
      s2_fbd_q    <= fbd_d;
    end
    if (en_out && s2_v_q) begin
      out_q <= y_d;
    end
  end

  assign out_valid_o  = out_v_q;
  assign sample_out_o = out_q;

endmodule

>>> rtl/reverb_comb_allpass_delay_unit.sv
`timescale 1ns / 1ps
// Reverb section: a feedback comb filter with dry and wet gains, or an allpass filter,
// on a 4096-entry circular delay line held in one synchronous RAM. Each input transaction
// gives one output transaction, passing through stage 1, stage 2 and the output register.
// With a delay length of three or more a new sample is taken every cycle unless the output
// stalls; at length one or two a sample that reads the entry still being updated by an
// earlier sample in the pipeline waits until that write-back lands in the RAM.
// The delay RAM needs no clearing pass after reset: data read on the first pass through the
// line is not used, and that pass writes every entry before its contents are used.
// depends on rcad_pkg, rcad_ram, rcad_line_ctrl, rcad_pipe
module reverb_comb_allpass_delay_unit
  import rcad_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration write port
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  // input samples
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [SMP_W-1:0]  sample_in_i,
  // output samples
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [SMP_W-1:0]  sample_out_o
);

  logic                    filter_mode_q;
  logic signed [SMP_W-1:0] dry_gain_q, wet_gain_q, feedback_gain_q;
  logic [DLEN_W-1:0]       delay_length_q;

  line_pos_t               pos;
  logic                    accept;
  logic                    ram_re, ram_we;
  logic [PTR_W-1:0]        ram_raddr, ram_waddr;
  logic [SMP_W-1:0]        ram_rdata, ram_wdata;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_mode_q   <= MODE_COMB;
      dry_gain_q      <= DRY_GAIN_RST;
      wet_gain_q      <= WET_GAIN_RST;
      feedback_gain_q <= FEEDBACK_GAIN_RST;
      delay_length_q  <= DELAY_LENGTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FILTER_MODE:   filter_mode_q   <= cfg_data_i[0];
        CFG_DRY_GAIN:      dry_gain_q      <= $signed(cfg_data_i[SMP_W-1:0]);
        CFG_WET_GAIN:      wet_gain_q      <= $signed(cfg_data_i[SMP_W-1:0]);
        CFG_FEEDBACK_GAIN: feedback_gain_q <= $signed(cfg_data_i[SMP_W-1:0]);
        CFG_DELAY_LENGTH:  delay_length_q  <= cfg_data_i[DLEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // delay line pointer
  rcad_line_ctrl u_line_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .delay_length_i (delay_length_q),
    .advance_i      (accept),
    .pos_o          (pos)
  );

  // sample pipeline
  rcad_pipe u_pipe (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .sample_in_i     (sample_in_i),
    .accept_o        (accept),
    .pos_i           (pos),
    .filter_mode_i   (filter_mode_q),
    .dry_gain_i      (dry_gain_q),
    .wet_gain_i      (wet_gain_q),
    .feedback_gain_i (feedback_gain_q),
    .ram_re_o        (ram_re),
    .ram_raddr_o     (ram_raddr),
    .ram_rdata_i     (ram_rdata),
    .ram_we_o        (ram_we),
    .ram_waddr_o     (ram_waddr),
    .ram_wdata_o     (ram_wdata),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .sample_out_o    (sample_out_o)
  );

  // delay line storage
  rcad_ram #(
    .WIDTH (SMP_W),
    .DEPTH (DELAY_DEPTH)
  ) u_delay_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

>>> rtl/rcad_checker.sv
`timescale 1ns / 1ps
// port-level checker for the reverb delay unit, bound to the top level
// depends on reverb_comb_allpass_delay_unit_defines.svh
`include "reverb_comb_allpass_delay_unit_defines.svh"

module rcad_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic [15:0] sample_out_o
);

  logic [2:0] pend_q, pend_d;
  logic       in_acc, out_acc;

  // transactions accepted but not yet delivered
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  always_comb begin
    pend_d = pend_q;
    if (in_acc && !out_acc) begin
      pend_d = pend_q + 3'd1;
    end else if (out_acc && !in_acc) begin
      pend_d = pend_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 3'd0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // a stalled result holds
  `RCAD_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(sample_out_o))
  // no result without a pending input
  `RCAD_ASSERT_NOW(a_no_spurious_out, out_valid_o, pend_q != 3'd0)
  // pipeline holds at most three samples
  `RCAD_ASSERT_NOW(a_pend_bound, 1'b1, pend_q <= 3'd3)
  // an empty pipeline always takes input
  `RCAD_ASSERT_NOW(a_empty_ready, pend_q == 3'd0, !in_stall_o)

endmodule

bind reverb_comb_allpass_delay_unit rcad_checker u_rcad_checker (.*);
